// ===== design/ths_pkg.sv =====
`default_nettype none
package ths_pkg;

  // Fraction bits of the Q16.16 format and of the cell position.
  localparam int FRAC_W = 16;
  // Width of the points-in-use register and of (points - 1).
  localparam int PW = 8;
  // Quotient bits of the scaled position: cell index and fraction.
  localparam int QW = PW + FRAC_W;
  // Width of the terrain size register and of an in-range offset.
  localparam int TW = 31;
  // Width of offset * (points - 1).
  localparam int SW = TW + PW;
  // Default grid side.
  localparam int GRID_POINTS_DEF = 128;
  // Depth of the queue between front and back.
  localparam int FQ_DEPTH = 4;
  localparam logic [FRAC_W:0] ONE_Q16 = 17'h10000;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_ORIGIN_X   = 2'd0,
    REG_ORIGIN_Z   = 2'd1,
    REG_TERRAIN_SZ = 2'd2,
    REG_POINTS     = 2'd3
  } cfg_reg_e;

  // Request kinds.
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Classified item passed from front to back.
  typedef struct packed {
    logic          query;
    logic          hit;
    logic          wr_ok;
    logic [6:0]    grid_x;
    logic [6:0]    grid_z;
    logic [31:0]   hval;
    logic [TW-1:0] tx;
    logic [TW-1:0] tz;
  } fe_item_t;

endpackage
`default_nettype wire

// ===== design/ths_front.sv =====
`default_nettype none
module ths_front #(
  parameter int GRID_POINTS = ths_pkg::GRID_POINTS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_query,
  input  logic [6:0]             grid_x,
  input  logic [6:0]             grid_z,
  input  logic [31:0]            hval,
  input  logic signed [31:0]     world_x,
  input  logic signed [31:0]     world_z,
  input  logic signed [31:0]     origin_x,
  input  logic signed [31:0]     origin_z,
  input  logic [ths_pkg::TW-1:0] ts,
  input  logic                   fq_full,
  output logic                   fq_push,
  output ths_pkg::fe_item_t      fq_item
);
  import ths_pkg::*;

  logic            fe_valid_r;
  fe_item_t        fe_item_r;
  fe_item_t        item_c;
  logic signed [32:0] tx_c;
  logic signed [32:0] tz_c;
  logic            ix_c;
  logic            iz_c;

  // The stage takes an item when empty or when its item moves into the queue.
  assign in_ready = !fe_valid_r || !fq_full;
  assign fq_push  = fe_valid_r && !fq_full;
  assign fq_item  = fe_item_r;

  // Offset from the origin; inside when 0 <= offset < terrain size on both axes.
  always_comb begin
    tx_c = 33'(world_x) - 33'(origin_x);
    tz_c = 33'(world_z) - 33'(origin_z);
    ix_c = !tx_c[32] && (tx_c[31:0] < {1'b0, ts});
    iz_c = !tz_c[32] && (tz_c[31:0] < {1'b0, ts});
    item_c.query  = (in_query == REQ_QUERY);
    item_c.hit    = ix_c && iz_c;
    item_c.wr_ok  = (32'(grid_x) < 32'(GRID_POINTS)) && (32'(grid_z) < 32'(GRID_POINTS));
    item_c.grid_x = grid_x;
    item_c.grid_z = grid_z;
    item_c.hval   = hval;
    item_c.tx     = tx_c[TW-1:0];
    item_c.tz     = tz_c[TW-1:0];
  end

  // Front register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fe_valid_r <= 1'b0;
    end else if (in_ready) begin
      fe_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      fe_item_r <= item_c;
    end
  end

endmodule
`default_nettype wire

// ===== design/ths_fifo.sv =====
`default_nettype none
module ths_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ths_pkg::fe_item_t item_in,
  input  logic              pop,
  output ths_pkg::fe_item_t item_out,
  output logic              full,
  output logic              empty
);
  import ths_pkg::*;

  localparam int AW = $clog2(FQ_DEPTH);

  fe_item_t        mem_r [FQ_DEPTH];
  logic [AW-1:0]   wp_r;
  logic [AW-1:0]   rp_r;
  logic [AW:0]     cnt_r;

  assign full     = (cnt_r == (AW+1)'(FQ_DEPTH));
  assign empty    = (cnt_r == '0);
  assign item_out = mem_r[rp_r];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= item_in;
    end
  end

endmodule
`default_nettype wire

// ===== design/ths_div.sv =====
`default_nettype none
module ths_div (
  input  logic                   clk,
  input  logic                   en,
  input  logic [ths_pkg::TW-1:0] ts,
  input  logic [ths_pkg::SW-1:0] s_in,
  output logic [ths_pkg::QW-1:0] q_out
);
  import ths_pkg::*;

  // Restoring division of s * 2^16 by the terrain size, one quotient bit
  // per stage. The caller guarantees s < (points - 1) * ts, so the
  // quotient fits QW bits and the leading part of the dividend is below ts.
  logic [TW-1:0] rem_r [QW];
  logic [QW-1:0] q_r   [QW];
  logic [QW-1:0] l_r   [QW];

  genvar i;
  generate
    for (i = 0; i < QW; i++) begin : g_stage
      logic [TW-1:0] rem_in;
      logic [QW-1:0] q_in;
      logic [QW-1:0] l_in;
      logic [TW:0]   cand;
      logic          ge;

      if (i == 0) begin : g_first
        assign rem_in = TW'(s_in >> PW);
        assign q_in   = '0;
        assign l_in   = {s_in[PW-1:0], {FRAC_W{1'b0}}};
      end else begin : g_next
        assign rem_in = rem_r[i-1];
        assign q_in   = q_r[i-1];
        assign l_in   = l_r[i-1];
      end

      // One compare and subtract.
      always_comb begin
        cand = {rem_in, l_in[QW-1]};
        ge   = (cand >= {1'b0, ts});
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[i] <= ge ? TW'(cand - {1'b0, ts}) : cand[TW-1:0];
          q_r[i]   <= {q_in[QW-2:0], ge};
          l_r[i]   <= {l_in[QW-2:0], 1'b0};
        end
      end
    end
  endgenerate

  assign q_out = q_r[QW-1];

endmodule
`default_nettype wire

// ===== design/ths_back.sv =====
`default_nettype none
module ths_back #(
  parameter int GRID_POINTS = ths_pkg::GRID_POINTS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ths_pkg::fe_item_t      fq_item,
  input  logic                   fq_empty,
  output logic                   fq_pop,
  input  logic [ths_pkg::TW-1:0] ts,
  input  logic [ths_pkg::PW-1:0] pm1,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [31:0]            out_height,
  output logic                   out_in_grid
);
  import ths_pkg::*;

  localparam int XW  = (GRID_POINTS > 1) ? $clog2(GRID_POINTS) : 1;
  localparam int HD  = (GRID_POINTS + 1) / 2;
  localparam int HXW = (HD > 1) ? $clog2(HD) : 1;
  localparam int MD  = 1 << (2 * HXW);

  typedef struct packed {
    logic        valid;
    logic        query;
    logic        hit;
    logic        wr_ok;
    logic [6:0]  grid_x;
    logic [6:0]  grid_z;
    logic [31:0] hval;
  } sb_t;

  logic en;
  assign en     = !out_valid || out_ready;
  assign fq_pop = en && !fq_empty;

  // Entry stage: scale the offsets by (points - 1).
  sb_t           sb_r [QW+1];
  logic [SW-1:0] sx_r;
  logic [SW-1:0] sz_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sx_r <= SW'(fq_item.tx) * SW'(pm1);
      sz_r <= SW'(fq_item.tz) * SW'(pm1);
    end
  end

  // Sideband runs beside the dividers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= QW; k++) begin
        sb_r[k] <= '0;
      end
    end else if (en) begin
      sb_r[0].valid  <= fq_pop;
      sb_r[0].query  <= fq_item.query;
      sb_r[0].hit    <= fq_item.hit;
      sb_r[0].wr_ok  <= fq_item.wr_ok;
      sb_r[0].grid_x <= fq_item.grid_x;
      sb_r[0].grid_z <= fq_item.grid_z;
      sb_r[0].hval   <= fq_item.hval;
      for (int k = 1; k <= QW; k++) begin
        sb_r[k] <= sb_r[k-1];
      end
    end
  end

  logic [QW-1:0] qx;
  logic [QW-1:0] qz;

  ths_div u_divx (.clk(clk), .en(en), .ts(ts), .s_in(sx_r), .q_out(qx));
  ths_div u_divz (.clk(clk), .en(en), .ts(ts), .s_in(sz_r), .q_out(qz));

  // Memory stage: four banks by coordinate parity, so the four corners of a
  // cell fall in four different banks.
  sb_t             sbd;
  logic [PW-1:0]   gx;
  logic [PW-1:0]   gz;
  logic [XW-1:0]   wxs;
  logic [XW-1:0]   wzs;
  logic [31:0]     rd_r [4];
  logic            m_v_r;
  logic            m_inside_r;
  logic [FRAC_W-1:0] m_fx_r;
  logic [FRAC_W-1:0] m_fz_r;
  logic            m_px_r;
  logic            m_pz_r;

  assign sbd = sb_r[QW];
  assign gx  = qx[QW-1:FRAC_W];
  assign gz  = qz[QW-1:FRAC_W];
  assign wxs = XW'(sbd.grid_x);
  assign wzs = XW'(sbd.grid_z);

  genvar b;
  generate
    for (b = 0; b < 4; b++) begin : g_bank
      localparam bit BX = (b >= 2);
      localparam bit BZ = (b % 2 == 1);
      logic [31:0]       mem_r [MD];
      logic [XW-1:0]     xb;
      logic [XW-1:0]     zb;
      logic [2*HXW-1:0]  ra;
      logic [2*HXW-1:0]  wa;
      logic              we;

      always_comb begin
        xb = XW'(gx) + XW'(gx[0] ^ BX);
        zb = XW'(gz) + XW'(gz[0] ^ BZ);
        ra = {HXW'(xb >> 1), HXW'(zb >> 1)};
        wa = {HXW'(wxs >> 1), HXW'(wzs >> 1)};
        we = en && sbd.valid && !sbd.query && sbd.wr_ok
             && (wxs[0] == BX) && (wzs[0] == BZ);
      end

      always_ff @(posedge clk) begin
        if (we) begin
          mem_r[wa] <= sbd.hval;
        end
        if (en) begin
          rd_r[b] <= mem_r[ra];
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
    end else if (en) begin
      m_v_r <= sbd.valid && sbd.query;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_inside_r <= sbd.hit;
      m_fx_r     <= qx[FRAC_W-1:0];
      m_fz_r     <= qz[FRAC_W-1:0];
      m_px_r     <= gx[0];
      m_pz_r     <= gz[0];
    end
  end

  // Weight stage: pick the triangle, its corner heights and weights.
  logic [31:0]     h00;
  logic [31:0]     h10;
  logic [31:0]     h01;
  logic [31:0]     h11;
  logic [FRAC_W:0] fsum;
  logic            upper;
  logic            w_v_r;
  logic            w_inside_r;
  logic [FRAC_W:0] wa_r;
  logic [FRAC_W:0] wb_r;
  logic [FRAC_W:0] wc_r;
  logic signed [31:0] ha_r;
  logic signed [31:0] hb_r;
  logic signed [31:0] hc_r;

  always_comb begin
    h00   = rd_r[{m_px_r, m_pz_r}];
    h10   = rd_r[{!m_px_r, m_pz_r}];
    h01   = rd_r[{m_px_r, !m_pz_r}];
    h11   = rd_r[{!m_px_r, !m_pz_r}];
    fsum  = {1'b0, m_fx_r} + {1'b0, m_fz_r};
    upper = (fsum > ONE_Q16);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_v_r <= 1'b0;
    end else if (en) begin
      w_v_r <= m_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w_inside_r <= m_inside_r;
      if (upper) begin
        ha_r <= h10;
        hb_r <= h11;
        hc_r <= h01;
        wa_r <= ONE_Q16 - {1'b0, m_fz_r};
        wb_r <= fsum - ONE_Q16;
        wc_r <= ONE_Q16 - {1'b0, m_fx_r};
      end else begin
        ha_r <= h00;
        hb_r <= h10;
        hc_r <= h01;
        wa_r <= ONE_Q16 - fsum;
        wb_r <= {1'b0, m_fx_r};
        wc_r <= {1'b0, m_fz_r};
      end
    end
  end

  // Product stage.
  logic               p_v_r;
  logic               p_inside_r;
  logic signed [49:0] pa_r;
  logic signed [49:0] pb_r;
  logic signed [49:0] pc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
    end else if (en) begin
      p_v_r <= w_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_inside_r <= w_inside_r;
      pa_r <= $signed({1'b0, wa_r}) * ha_r;
      pb_r <= $signed({1'b0, wb_r}) * hb_r;
      pc_r <= $signed({1'b0, wc_r}) * hc_r;
    end
  end

  // Sum stage.
  logic               s_v_r;
  logic               s_inside_r;
  logic signed [51:0] sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_v_r <= 1'b0;
    end else if (en) begin
      s_v_r <= p_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_inside_r <= p_inside_r;
      sum_r      <= 52'(pa_r) + 52'(pb_r) + 52'(pc_r);
    end
  end

  // Round to nearest, ties up, then saturate into the output register.
  logic signed [51:0] rnd;
  logic signed [51:0] shr;
  logic [31:0]        sat;
  logic               out_valid_r;
  logic [31:0]        out_height_r;
  logic               out_in_grid_r;

  always_comb begin
    rnd = sum_r + 52'sd32768;
    shr = rnd >>> FRAC_W;
    if (shr > 52'sd2147483647) begin
      sat = 32'h7FFF_FFFF;
    end else if (shr < -52'sd2147483648) begin
      sat = 32'h8000_0000;
    end else begin
      sat = shr[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= s_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_height_r  <= s_inside_r ? sat : 32'd0;
      out_in_grid_r <= s_inside_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_height  = out_height_r;
  assign out_in_grid = out_in_grid_r;

endmodule
`default_nettype wire

// ===== design/terrain_height_sampler_top.sv =====
`default_nettype none
// Channel  | Direction | Payload
// in_      | slave     | tuser: req_type; tdata: grid_x, grid_z, height_value,
//          |           | world_x, world_z
// out_     | master    | tuser: in_grid; tdata: height
// cfg_     | slave     | cfg_index: register, cfg_data: value
//
// One item per cycle is taken and one result per cycle is given while out_tready
// is high; a query passes through the 24-stage cell divider on its way out.
// Reset clears control state only; the height banks need no clearing pass.
// A stall on out_tready freezes the back pipeline; the four-entry queue
// lets the front keep taking items until it fills.
module terrain_height_sampler_top #(
  parameter int GRID_POINTS = ths_pkg::GRID_POINTS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [111:0] in_tdata,   // grid_x, grid_z, height_value, world_x, world_z, zero pad
  input  logic         in_tuser,   // req_type
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [31:0]  out_tdata,  // height
  output logic         out_tuser,  // in_grid
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import ths_pkg::*;

  logic signed [31:0] origin_x_r;
  logic signed [31:0] origin_z_r;
  logic [TW-1:0]      terrain_size_r;
  logic [PW-1:0]      points_r;
  logic [PW-1:0]      pm1;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r     <= '0;
      origin_z_r     <= '0;
      terrain_size_r <= 31'd52428800;
      points_r       <= 8'd128;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ORIGIN_X:   origin_x_r     <= cfg_data;
        REG_ORIGIN_Z:   origin_z_r     <= cfg_data;
        REG_TERRAIN_SZ: terrain_size_r <= cfg_data[TW-1:0];
        REG_POINTS:     points_r       <= cfg_data[PW-1:0];
        default: ;
      endcase
    end
  end

  // Points in use, held between two and the grid side, minus one.
  always_comb begin
    if (points_r < 8'd2) begin
      pm1 = PW'(1);
    end else if (32'(points_r) > 32'(GRID_POINTS)) begin
      pm1 = PW'(GRID_POINTS - 1);
    end else begin
      pm1 = points_r - 8'd1;
    end
  end

  fe_item_t fq_in;
  fe_item_t fq_out;
  logic     fq_push;
  logic     fq_pop;
  logic     fq_full;
  logic     fq_empty;

  ths_front #(.GRID_POINTS(GRID_POINTS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_query (in_tuser),
    .grid_x   (in_tdata[6:0]),
    .grid_z   (in_tdata[13:7]),
    .hval     (in_tdata[45:14]),
    .world_x  (in_tdata[77:46]),
    .world_z  (in_tdata[109:78]),
    .origin_x (origin_x_r),
    .origin_z (origin_z_r),
    .ts       (terrain_size_r),
    .fq_full  (fq_full),
    .fq_push  (fq_push),
    .fq_item  (fq_in)
  );

  ths_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (fq_push),
    .item_in  (fq_in),
    .pop      (fq_pop),
    .item_out (fq_out),
    .full     (fq_full),
    .empty    (fq_empty)
  );

  ths_back #(.GRID_POINTS(GRID_POINTS)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .fq_item     (fq_out),
    .fq_empty    (fq_empty),
    .fq_pop      (fq_pop),
    .ts          (terrain_size_r),
    .pm1         (pm1),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_height  (out_tdata),
    .out_in_grid (out_tuser)
  );

  // The front never pushes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    fq_push |-> !fq_full) else $error("queue overflow");

  // A query outside the grid reports zero height.
  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == 32'd0) else $error("outside height not zero");

  // No result comes out in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid) else $error("result after reset");

endmodule
`default_nettype wire
